// File: design/quadratic_probe_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probe hash table
// Concurrent checks clocked on the rising edge, masked while in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define QPHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Block clock and reset.
`define QPHT_ASSERT_CLK(label, prop, msg) \
  `QPHT_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// File: design/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared widths, reset values, operation codes and memory control type.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned KEY_W        = 31;
  localparam int unsigned KEY_TDATA_W  = 32;
  localparam int unsigned SLOT_W       = 14;
  localparam int unsigned SLOT_TDATA_W = 16;
  localparam int unsigned SIZE_W       = 15;
  localparam int unsigned BIT_CNT_W    = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 15'd16381;
  localparam int unsigned MAX_SLOTS_DEF = 16384;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_DELETE = 2'd2
  } func_e;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic occ_we;
    logic occ_wdata;
  } mem_ctl_t;

endpackage

// File: design/qpht_alu.sv
// ----------------------------------------------------------------------------
// qpht_alu
// Shared compare-and-subtract unit: y = (a >= b) ? a - b : a.
// ----------------------------------------------------------------------------
module qpht_alu #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-2:0] b_i,
  output logic [W-2:0] y_o
);

  logic [W-1:0] b_ext;
  logic [W-1:0] diff;
  logic         ge;

  assign b_ext = {1'b0, b_i};
  assign ge    = (a_i >= b_ext);
  assign diff  = a_i - b_ext;
  // callers keep a below 2*b, so the result fits one bit narrower
  assign y_o   = ge ? diff[W-2:0] : a_i[W-2:0];

endmodule

// File: design/qpht_mem.sv
// ----------------------------------------------------------------------------
// qpht_mem
// Slot storage: key memory and occupied-flag memory, one read and one write
// port each, registered read data.
// ----------------------------------------------------------------------------
module qpht_mem #(
  parameter int unsigned DEPTH = qpht_pkg::MAX_SLOTS_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  qpht_pkg::mem_ctl_t            ctl_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic [qpht_pkg::KEY_W-1:0]    key_wdata_i,
  output logic                          occ_rd_o,
  output logic [qpht_pkg::KEY_W-1:0]    key_rd_o
);

  logic [qpht_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic                       occ_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[wr_addr_i] <= key_wdata_i;
    end
    if (ctl_i.rd_en) begin
      key_rd_o <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.occ_we) begin
      occ_mem[wr_addr_i] <= ctl_i.occ_wdata;
    end
    if (ctl_i.rd_en) begin
      occ_rd_o <= occ_mem[rd_addr_i];
    end
  end

endmodule

// File: design/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing (insert, search, delete).
// ----------------------------------------------------------------------------
// One operation at a time. After reset the block sweeps the occupied flags,
// one slot per cycle, through all MAX_SLOTS slots before it takes its first item;
// table_size writes are taken throughout. An operation first finds the home
// slot by a bit-serial remainder through the shared compare-subtract unit, then
// probes until a hit or until table_size probes are spent; each probe is one
// memory read plus updates of the offset and the slot through that unit. The
// result then goes to the output register, which waits while the output stalls.
// Zero table_size and unused function codes go straight to the response. Probe offsets are built
// incrementally ((i+1)^2 = i^2 + 2i + 1), all kept below table_size.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_assert.svh"

module quadratic_probe_hash_table #(
  parameter int unsigned MAX_SLOTS = qpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration: table_size
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [qpht_pkg::SIZE_W-1:0]           cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [qpht_pkg::KEY_TDATA_W-1:0]      s_axis_tdata,  // [30:0] key
  input  logic [qpht_pkg::FUNC_W-1:0]           s_axis_tuser,  // [1:0] func
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [qpht_pkg::SLOT_TDATA_W-1:0]     m_axis_tdata,  // [13:0] slot
  output logic                                  m_axis_tuser   // [0] ok
);

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW    = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > qpht_pkg::SIZE_W) ? CNT_W : qpht_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_RESP
  } state_e;

  state_e                              state_q;
  logic [qpht_pkg::SIZE_W-1:0]         size_q;
  logic [IDX_W-1:0]                    clr_cnt_q;
  qpht_pkg::func_e                     func_q;
  logic [qpht_pkg::KEY_W-1:0]          key_q;
  logic [qpht_pkg::BIT_CNT_W-1:0]      bit_q;
  logic [CNT_W-1:0]                    pos_q;
  logic [CNT_W-1:0]                    delta_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic                                res_ok_q;
  logic                                m_valid_q;
  logic [qpht_pkg::SLOT_TDATA_W-1:0]   m_data_q;
  logic                                m_ok_q;

  logic [CMP_W-1:0]                    size_ext;
  logic [CMP_W-1:0]                    max_ext;
  logic [CNT_W-1:0]                    size_act;
  logic [AW-1:0]                       alu_a;
  logic [CNT_W-1:0]                    alu_y;
  qpht_pkg::mem_ctl_t                  mem_ctl;
  logic [IDX_W-1:0]                    wr_addr;
  logic                                occ_rd;
  logic [qpht_pkg::KEY_W-1:0]          key_rd;
  logic                                hit;
  logic                                in_xfer;
  logic                                func_ok;

  // sizes above the table depth clamp to the depth
  assign size_ext = CMP_W'(size_q);
  assign max_ext  = CMP_W'(MAX_SLOTS);
  assign size_act = CNT_W'((size_ext > max_ext) ? max_ext : size_ext);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign func_ok       = (s_axis_tuser == qpht_pkg::FN_INSERT) ||
                         (s_axis_tuser == qpht_pkg::FN_SEARCH) ||
                         (s_axis_tuser == qpht_pkg::FN_DELETE);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= qpht_pkg::SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // shared unit operand select
  always_comb begin
    unique case (state_q)
      S_DIV:   alu_a = {pos_q, key_q[bit_q]};
      S_READ:  alu_a = {1'b0, delta_q} + AW'(2);
      S_CHECK: alu_a = {1'b0, pos_q} + {1'b0, delta_q};
      default: alu_a = '0;
    endcase
  end

  qpht_alu #(
    .W (AW)
  ) u_alu (
    .a_i (alu_a),
    .b_i (size_act),
    .y_o (alu_y)
  );

  always_comb begin
    if (func_q == qpht_pkg::FN_INSERT) begin
      hit = !occ_rd;
    end else begin
      hit = occ_rd && (key_rd == key_q);
    end
  end

  // search leaves the flags alone; insert sets, delete clears
  always_comb begin
    mem_ctl = '0;
    mem_ctl.rd_en = (state_q == S_READ);
    if (state_q == S_CLEAR) begin
      mem_ctl.occ_we = 1'b1;
    end else if (state_q == S_CHECK && hit && func_q != qpht_pkg::FN_SEARCH) begin
      mem_ctl.occ_we    = 1'b1;
      mem_ctl.key_we    = (func_q == qpht_pkg::FN_INSERT);
      mem_ctl.occ_wdata = (func_q == qpht_pkg::FN_INSERT);
    end
  end

  assign wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : pos_q[IDX_W-1:0];

  qpht_mem #(
    .DEPTH (MAX_SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .rd_addr_i   (pos_q[IDX_W-1:0]),
    .wr_addr_i   (wr_addr),
    .key_wdata_i (key_q),
    .occ_rd_o    (occ_rd),
    .key_rd_o    (key_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // S_RESP either reloads the output register or holds it while stalled
      if (m_axis_tready && state_q != S_RESP) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + IDX_W'(1);
          if (clr_cnt_q == IDX_W'(MAX_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            func_q <= qpht_pkg::func_e'(s_axis_tuser);
            key_q  <= s_axis_tdata[qpht_pkg::KEY_W-1:0];
            pos_q  <= '0;
            bit_q  <= qpht_pkg::BIT_CNT_W'(qpht_pkg::KEY_W - 1);
            if (size_act == '0 || !func_ok) begin
              res_ok_q <= 1'b0;
              state_q  <= S_RESP;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring remainder, MSB first; pos_q holds the partial remainder
          pos_q <= alu_y;
          bit_q <= bit_q - qpht_pkg::BIT_CNT_W'(1);
          if (bit_q == '0) begin
            delta_q <= size_act - CNT_W'(1);
            cnt_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          delta_q <= alu_y;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            res_ok_q <= 1'b1;
            state_q  <= S_RESP;
          end else if (cnt_q == size_act - CNT_W'(1)) begin
            res_ok_q <= 1'b0;
            state_q  <= S_RESP;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            pos_q   <= alu_y;
            state_q <= S_READ;
          end
        end
        S_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_ok_q    <= res_ok_q;
            m_data_q  <= res_ok_q ? qpht_pkg::SLOT_TDATA_W'(qpht_pkg::SLOT_W'(pos_q)) : '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  `QPHT_ASSERT_CLK(a_one_item_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while busy")
  `QPHT_ASSERT_CLK(a_fail_slot_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "failed result with nonzero slot")
  `QPHT_ASSERT_CLK(a_probe_in_range, (state_q == S_READ || state_q == S_CHECK) |-> (pos_q < size_act), "probe slot outside table")
  `QPHT_ASSERT_CLK(a_flag_write_source, mem_ctl.occ_we |-> (state_q == S_CLEAR || state_q == S_CHECK), "flag write outside clear or check")

endmodule
